// File: rtl/distance_falloff_weight_unit_defines.svh
// ----------------------------------------------------------------------------
// distance_falloff_weight_unit_defines
// Assertion shorthands shared by the weight unit modules. Each expects the
// module to have i_clk and an active-low i_rst_n.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_FALLOFF_WEIGHT_UNIT_DEFINES_SVH
`define DISTANCE_FALLOFF_WEIGHT_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define DFW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define DFW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dfw_pkg.sv
// ----------------------------------------------------------------------------
// dfw_pkg
// Types and constants shared by the distance falloff weight unit.
// ----------------------------------------------------------------------------
package dfw_pkg;

    localparam int COORD_W  = 24;
    localparam int DIFF_W   = 25;
    localparam int RADIUS_W = 23;
    localparam int WEIGHT_W = 17;
    localparam int CFG_IDX_W = 4;

    localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 17'd65536;
    localparam logic [RADIUS_W-1:0] OUTER_RESET = 23'd25600;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [RADIUS_W-1:0] t_radius;
    typedef logic        [WEIGHT_W-1:0] t_weight;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X      = 4'd0,
        CFG_START_Y      = 4'd1,
        CFG_START_Z      = 4'd2,
        CFG_END_X        = 4'd3,
        CFG_END_Y        = 4'd4,
        CFG_END_Z        = 4'd5,
        CFG_INNER_RADIUS = 4'd6,
        CFG_OUTER_RADIUS = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        t_coord sx;
        t_coord sy;
        t_coord sz;
        t_coord ex;
        t_coord ey;
        t_coord ez;
    } t_dfw_seg;

    typedef struct packed {
        t_radius inner;
        t_radius outer;
    } t_dfw_radii;

    // Vertex minus start (w) and end minus start (d), per axis
    typedef struct packed {
        logic [2:0][DIFF_W-1:0] w;
        logic [2:0][DIFF_W-1:0] d;
    } t_dfw_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Which point of the segment is nearest
    typedef enum logic [1:0] {
        NEAR_START = 2'd0,
        NEAR_END   = 2'd1,
        NEAR_INNER = 2'd2
    } t_near;

    // How the final weight is formed
    typedef enum logic [1:0] {
        WC_FULL = 2'd0,
        WC_ZERO = 2'd1,
        WC_DIV  = 2'd2
    } t_wcode;

endpackage

// File: rtl/dfw_queue.sv
// ----------------------------------------------------------------------------
// dfw_queue
// Small register-based first-in first-out queue with count and status.
// ----------------------------------------------------------------------------
`include "distance_falloff_weight_unit_defines.svh"

module dfw_queue
    import dfw_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;

    // Wrap pointers at the depth
    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    // Store requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    `DFW_ASSERT_NOW(a_no_overflow, i_push, !o_stat.full, "push into a full queue")
    `DFW_ASSERT_NOW(a_no_underflow, i_pop, !o_stat.empty, "pop from an empty queue")
    `DFW_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1, "count lost a push")

endmodule

// File: rtl/dfw_front.sv
// ----------------------------------------------------------------------------
// dfw_front
// Accepts vertices, forms offsets from the segment start and hands them on.
// ----------------------------------------------------------------------------
module dfw_front
    import dfw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_coord    i_vertex_x,
    input  t_coord    i_vertex_y,
    input  t_coord    i_vertex_z,
    input  t_dfw_seg  i_seg,
    input  t_q_stat   i_mid_stat,
    output logic      o_full,
    output logic      o_push,
    output t_dfw_item o_item
);

    logic      r_valid;
    t_dfw_item r_item;
    t_dfw_item n_item;
    logic      accept;

    assign o_full = r_valid && i_mid_stat.full;
    assign o_push = r_valid && !i_mid_stat.full;
    assign accept = i_push && !o_full;

    // Form vertex and segment offsets
    always_comb begin
        n_item.w[0] = DIFF_W'(i_vertex_x) - DIFF_W'(i_seg.sx);
        n_item.w[1] = DIFF_W'(i_vertex_y) - DIFF_W'(i_seg.sy);
        n_item.w[2] = DIFF_W'(i_vertex_z) - DIFF_W'(i_seg.sz);
        n_item.d[0] = DIFF_W'(i_seg.ex) - DIFF_W'(i_seg.sx);
        n_item.d[1] = DIFF_W'(i_seg.ey) - DIFF_W'(i_seg.sy);
        n_item.d[2] = DIFF_W'(i_seg.ez) - DIFF_W'(i_seg.sz);
    end

    // Hold the request until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// File: rtl/dfw_back.sv
// ----------------------------------------------------------------------------
// dfw_back
// Pipelined projection, nearest point, distance and falloff weight.
// ----------------------------------------------------------------------------
`include "distance_falloff_weight_unit_defines.svh"

module dfw_back
    import dfw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dfw_item  i_item,
    input  t_q_stat    i_mid_stat,
    input  t_dfw_radii i_radii,
    input  t_q_stat    i_out_stat,
    output logic       o_mid_pop,
    output logic       o_out_push,
    output t_weight    o_weight
);

    localparam int TQ_STEPS = 32;
    localparam int SQ_STEPS = 31;
    localparam int WQ_STEPS = 16;
    localparam int NST      = 3 + TQ_STEPS + 4 + SQ_STEPS + 1 + WQ_STEPS + 1;

    typedef struct packed {
        t_dfw_item item;
        t_near     near;
    } t_geo;

    logic [NST-1:0] r_vld;
    logic           en;

    // Whole pipeline moves unless the last stage is stuck
    assign en         = !r_vld[NST-1] || !i_out_stat.full;
    assign o_mid_pop  = en && !i_mid_stat.empty;
    assign o_out_push = en && r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], !i_mid_stat.empty};
        end
    end

    // ---------------- projection products ----------------
    logic signed [49:0] r_a_pw [3];
    logic        [48:0] r_a_dd [3];
    t_dfw_item          r_a_item;
    logic signed [49:0] a_pw [3];
    logic signed [49:0] a_dsq [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a_pw[k]  = $signed(i_item.w[k]) * $signed(i_item.d[k]);
            a_dsq[k] = $signed(i_item.d[k]) * $signed(i_item.d[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_a_pw[k] <= a_pw[k];
                r_a_dd[k] <= a_dsq[k][48:0];
            end
            r_a_item <= i_item;
        end
    end

    // Sum the dot products
    logic signed [51:0] r_b_tn;
    logic        [50:0] r_b_td;
    t_dfw_item          r_b_item;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_tn   <= 52'(r_a_pw[0]) + 52'(r_a_pw[1]) + 52'(r_a_pw[2]);
            r_b_td   <= 51'(r_a_dd[0]) + 51'(r_a_dd[1]) + 51'(r_a_dd[2]);
            r_b_item <= r_a_item;
        end
    end

    // Classify the nearest point
    logic [50:0] r_c_num;
    logic [50:0] r_c_den;
    t_geo        r_c_geo;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_num      <= r_b_tn[50:0];
            r_c_den      <= r_b_td;
            r_c_geo.item <= r_b_item;
            if (r_b_tn <= 52'sd0) begin
                r_c_geo.near <= NEAR_START;
            end else if (r_b_tn[50:0] >= r_b_td) begin
                r_c_geo.near <= NEAR_END;
            end else begin
                r_c_geo.near <= NEAR_INNER;
            end
        end
    end

    // ---------------- projection parameter, one quotient bit a stage ----------------
    logic [50:0] r_t_rem [TQ_STEPS];
    logic [50:0] r_t_den [TQ_STEPS];
    logic [31:0] r_t_q   [TQ_STEPS];
    t_geo        r_t_geo [TQ_STEPS];

    for (genvar j = 0; j < TQ_STEPS; j++) begin : g_tdiv
        logic [50:0] rem_in;
        logic [50:0] den_in;
        logic [31:0] q_in;
        t_geo        geo_in;
        logic [51:0] rem2;

        if (j == 0) begin : g_first
            assign rem_in = r_c_num;
            assign den_in = r_c_den;
            assign q_in   = '0;
            assign geo_in = r_c_geo;
        end else begin : g_next
            assign rem_in = r_t_rem[j-1];
            assign den_in = r_t_den[j-1];
            assign q_in   = r_t_q[j-1];
            assign geo_in = r_t_geo[j-1];
        end

        assign rem2 = {rem_in, 1'b0};

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (rem2 >= 52'(den_in)) begin
                    r_t_rem[j] <= 51'(rem2 - 52'(den_in));
                    r_t_q[j]   <= {q_in[30:0], 1'b1};
                end else begin
                    r_t_rem[j] <= rem2[50:0];
                    r_t_q[j]   <= {q_in[30:0], 1'b0};
                end
                r_t_den[j] <= den_in;
                r_t_geo[j] <= geo_in;
            end
        end
    end

    // ---------------- nearest point offsets ----------------
    logic [24:0] r_m1_m [3];
    t_geo        r_m1_geo;
    logic [24:0] m1_mag [3];
    logic [56:0] m1_mt  [3];
    logic [57:0] m1_rnd [3];
    logic signed [24:0] m1_d [3];

    // Scale |d| by the parameter, round half away from zero
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            m1_d[k]   = $signed(r_t_geo[TQ_STEPS-1].item.d[k]);
            m1_mag[k] = m1_d[k][24] ? 25'(-m1_d[k]) : 25'(m1_d[k]);
            m1_mt[k]  = m1_mag[k] * r_t_q[TQ_STEPS-1];
            m1_rnd[k] = {1'b0, m1_mt[k]} + (58'(1) << 31);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_m1_m[k] <= m1_rnd[k][56:32];
            end
            r_m1_geo <= r_t_geo[TQ_STEPS-1];
        end
    end

    // Difference from vertex to the nearest point
    logic signed [26:0] r_m2_e [3];
    logic signed [26:0] m2_w [3];
    logic signed [26:0] m2_d [3];
    logic signed [26:0] m2_m [3];
    logic signed [26:0] m2_e [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            m2_w[k] = 27'($signed(r_m1_geo.item.w[k]));
            m2_d[k] = 27'($signed(r_m1_geo.item.d[k]));
            m2_m[k] = $signed({2'b00, r_m1_m[k]});
            case (r_m1_geo.near)
                NEAR_START: m2_e[k] = m2_w[k];
                NEAR_END:   m2_e[k] = m2_w[k] - m2_d[k];
                NEAR_INNER: m2_e[k] = m2_d[k][26] ? m2_w[k] + m2_m[k] : m2_w[k] - m2_m[k];
                default:    m2_e[k] = m2_w[k];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_m2_e[k] <= m2_e[k];
            end
        end
    end

    // Square the differences and the inner radius
    logic        [50:0] r_m3_sq [3];
    logic        [45:0] r_m3_in2;
    logic signed [53:0] m3_sq [3];
    logic        [45:0] m3_in2;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            m3_sq[k] = r_m2_e[k] * r_m2_e[k];
        end
        m3_in2 = i_radii.inner * i_radii.inner;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_m3_sq[k] <= m3_sq[k][50:0];
            end
            r_m3_in2 <= m3_in2;
        end
    end

    // Sum of squares and inside-inner check
    logic [51:0] r_s;
    logic        r_full;
    logic [51:0] m4_s;

    assign m4_s = 52'(r_m3_sq[0]) + 52'(r_m3_sq[1]) + 52'(r_m3_sq[2]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s    <= m4_s;
            r_full <= (m4_s <= 52'(r_m3_in2));
        end
    end

    // ---------------- square root, one root bit a stage ----------------
    logic [60:0] r_q_n    [SQ_STEPS];
    logic [60:0] r_q_root [SQ_STEPS];
    logic        r_q_full [SQ_STEPS];

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        localparam logic [60:0] BITV = 61'(1) << (60 - 2 * j);
        logic [60:0] n_in;
        logic [60:0] root_in;
        logic        full_in;
        logic [60:0] rb;

        if (j == 0) begin : g_first
            assign n_in    = {1'b0, r_s, 8'd0};
            assign root_in = '0;
            assign full_in = r_full;
        end else begin : g_next
            assign n_in    = r_q_n[j-1];
            assign root_in = r_q_root[j-1];
            assign full_in = r_q_full[j-1];
        end

        assign rb = root_in + BITV;

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (n_in >= rb) begin
                    r_q_n[j]    <= n_in - rb;
                    r_q_root[j] <= (root_in >> 1) + BITV;
                end else begin
                    r_q_n[j]    <= n_in;
                    r_q_root[j] <= root_in >> 1;
                end
                r_q_full[j] <= full_in;
            end
        end
    end

    // ---------------- falloff decision ----------------
    t_wcode      r_f_code;
    logic [26:0] r_f_num;
    logic [26:0] r_f_span;
    logic [30:0] f_dist;
    logic [30:0] f_ii;
    logic [30:0] f_num;
    logic [26:0] f_span;
    logic        f_step;
    t_wcode      f_code;

    always_comb begin
        f_dist = r_q_root[SQ_STEPS-1][30:0];
        f_ii   = {4'd0, i_radii.inner, 4'd0};
        f_num  = f_dist - f_ii;
        f_span = {i_radii.outer - i_radii.inner, 4'd0};
        f_step = (i_radii.outer <= i_radii.inner);
        if (r_q_full[SQ_STEPS-1]) begin
            f_code = WC_FULL;
        end else if (f_step) begin
            f_code = WC_ZERO;
        end else if (f_dist <= f_ii) begin
            f_code = WC_FULL;
        end else if (f_num >= {4'd0, f_span}) begin
            f_code = WC_ZERO;
        end else begin
            f_code = WC_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_code <= f_code;
            r_f_num  <= f_num[26:0];
            r_f_span <= f_span;
        end
    end

    // ---------------- falloff fraction, one quotient bit a stage ----------------
    logic [26:0] r_w_rem  [WQ_STEPS];
    logic [26:0] r_w_span [WQ_STEPS];
    logic [15:0] r_w_q    [WQ_STEPS];
    t_wcode      r_w_code [WQ_STEPS];

    for (genvar j = 0; j < WQ_STEPS; j++) begin : g_wdiv
        logic [26:0] rem_in;
        logic [26:0] span_in;
        logic [15:0] q_in;
        t_wcode      code_in;
        logic [27:0] rem2;

        if (j == 0) begin : g_first
            assign rem_in  = r_f_num;
            assign span_in = r_f_span;
            assign q_in    = '0;
            assign code_in = r_f_code;
        end else begin : g_next
            assign rem_in  = r_w_rem[j-1];
            assign span_in = r_w_span[j-1];
            assign q_in    = r_w_q[j-1];
            assign code_in = r_w_code[j-1];
        end

        assign rem2 = {rem_in, 1'b0};

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (rem2 >= {1'b0, span_in}) begin
                    r_w_rem[j] <= 27'(rem2 - {1'b0, span_in});
                    r_w_q[j]   <= {q_in[14:0], 1'b1};
                end else begin
                    r_w_rem[j] <= rem2[26:0];
                    r_w_q[j]   <= {q_in[14:0], 1'b0};
                end
                r_w_span[j] <= span_in;
                r_w_code[j] <= code_in;
            end
        end
    end

    // Form the weight
    t_weight r_weight;
    t_weight n_weight;

    always_comb begin
        case (r_w_code[WQ_STEPS-1])
            WC_FULL: n_weight = FULL_WEIGHT;
            WC_ZERO: n_weight = '0;
            WC_DIV:  n_weight = FULL_WEIGHT - WEIGHT_W'(r_w_q[WQ_STEPS-1]);
            default: n_weight = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_weight <= n_weight;
        end
    end

    assign o_weight = r_weight;

    `DFW_ASSERT_NEXT(a_hold_on_stall, r_vld[NST-1] && !en, r_vld[NST-1] && $stable(r_weight), "stall")
    `DFW_ASSERT_NOW(a_weight_range, r_vld[NST-1], r_weight <= FULL_WEIGHT, "weight above one")
    `DFW_ASSERT_NOW(a_out_room, o_out_push, !i_out_stat.full, "push into a full output queue")

endmodule

// File: rtl/distance_falloff_weight_unit.sv
// ----------------------------------------------------------------------------
// distance_falloff_weight_unit
// Selection weight of a vertex from its distance to a configured segment.
// ----------------------------------------------------------------------------
// Usage:
//   Vertices enter as a queue: drive i_vertex_x/y/z and raise push; the
//   vertex is taken at a clock edge where push is high and full is low.
//   Weights leave as a queue: o_weight holds the oldest weight while empty
//   is low, and it is taken at an edge where pop is high.
//   Segment ends and radii are written through i_cfg_valid/i_cfg_index/
//   i_cfg_data (o_cfg_ready is always high) while no vertex is in flight;
//   indexes beyond the outer radius are ignored.
//   Throughput is one vertex per cycle while the output queue has room. A
//   weight passes the 32-step projection divider, the 31-step square root
//   and the 16-step falloff divider in the back pipeline.
//   When pop stays low the output queue fills, the back pipeline holds,
//   the middle queue fills, and full rises; nothing is dropped.
//   Reset clears all queues, zeroes the segment and inner radius and sets
//   the outer radius to 100.0.
// ----------------------------------------------------------------------------
module distance_falloff_weight_unit
    import dfw_pkg::*;
#(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_coord               i_vertex_x,
    input  t_coord               i_vertex_y,
    input  t_coord               i_vertex_z,
    output logic                 empty,
    input  logic                 pop,
    output t_weight              o_weight,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data
);

    t_dfw_seg   r_seg;
    t_dfw_radii r_radii;

    t_q_stat    mid_stat;
    t_q_stat    out_stat;
    t_dfw_item  front_item;
    t_dfw_item  mid_item;
    logic       front_push;
    logic       mid_pop;
    logic       out_push;
    t_weight    back_weight;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg         <= '0;
            r_radii.inner <= '0;
            r_radii.outer <= OUTER_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_X:      r_seg.sx      <= i_cfg_data;
                CFG_START_Y:      r_seg.sy      <= i_cfg_data;
                CFG_START_Z:      r_seg.sz      <= i_cfg_data;
                CFG_END_X:        r_seg.ex      <= i_cfg_data;
                CFG_END_Y:        r_seg.ey      <= i_cfg_data;
                CFG_END_Z:        r_seg.ez      <= i_cfg_data;
                CFG_INNER_RADIUS: r_radii.inner <= i_cfg_data[RADIUS_W-1:0];
                CFG_OUTER_RADIUS: r_radii.outer <= i_cfg_data[RADIUS_W-1:0];
                default:          ;
            endcase
        end
    end

    dfw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_vertex_x (i_vertex_x),
        .i_vertex_y (i_vertex_y),
        .i_vertex_z (i_vertex_z),
        .i_seg      (r_seg),
        .i_mid_stat (mid_stat),
        .o_full     (full),
        .o_push     (front_push),
        .o_item     (front_item)
    );

    dfw_queue #(
        .WIDTH ($bits(t_dfw_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_item),
        .i_pop   (mid_pop),
        .o_data  (mid_item),
        .o_stat  (mid_stat)
    );

    dfw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (mid_item),
        .i_mid_stat (mid_stat),
        .i_radii    (r_radii),
        .i_out_stat (out_stat),
        .o_mid_pop  (mid_pop),
        .o_out_push (out_push),
        .o_weight   (back_weight)
    );

    dfw_queue #(
        .WIDTH (WEIGHT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_weight),
        .i_pop   (pop && !out_stat.empty),
        .o_data  (o_weight),
        .o_stat  (out_stat)
    );

    assign empty = out_stat.empty;

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the distance falloff weight unit against a predictor of its own.
// Vertices go in through the push/full queue and weights come out through
// the empty/pop queue. Both sides idle at random. The segment and radii are
// rewritten between phases while the unit is idle. Each weight is compared
// with the oldest predicted weight.
// ----------------------------------------------------------------------------
module tb_top;
    import dfw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 120;

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vertex;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    t_coord               i_vertex_x = '0;
    t_coord               i_vertex_y = '0;
    t_coord               i_vertex_z = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    t_weight              o_weight;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COORD_W-1:0]   i_cfg_data = '0;

    // Configuration copy, input backlog and predicted weights
    logic [COORD_W-1:0] seg_regs [8];
    t_vertex            vertex_backlog [$];
    t_weight            weight_fifo [$];

    bit  quiet_mode = 0;
    bit  vertex_taken = 0;
    int  push_gap = 0;
    int  pop_gap = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;

    distance_falloff_weight_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_vertex_x  (i_vertex_x),
        .i_vertex_y  (i_vertex_y),
        .i_vertex_z  (i_vertex_z),
        .empty       (empty),
        .pop         (pop),
        .o_weight    (o_weight),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // floor(num * 2^32 / den) by restoring division, num < den
    function automatic longint unsigned param_q32(longint unsigned num,
                                                  longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        rem = num;
        quo = 0;
        for (int i = 0; i < 32; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 1;
            end
        end
        return quo;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Weight of one vertex under the current segment and radii
    function automatic t_weight falloff_weight(t_vertex v);
        longint a [3];
        longint d [3];
        longint pt [3];
        longint vc [3];
        longint tn;
        longint e;
        longint unsigned td, s, inn, outr, root_d, ii, span, nm, tq, mag, m;
        vc[0] = v.x;
        vc[1] = v.y;
        vc[2] = v.z;
        tn = 0;
        td = 0;
        s = 0;
        for (int k = 0; k < 3; k++) begin
            a[k] = $signed(seg_regs[k]);
            d[k] = longint'($signed(seg_regs[3+k])) - a[k];
            tn += (vc[k] - a[k]) * d[k];
            td += d[k] * d[k];
        end
        // pick the nearest point: start, end or interior
        tq = (tn > 0 && longint'(td) > tn) ? param_q32(tn, td) : 0;
        for (int k = 0; k < 3; k++) begin
            if (tn <= 0) begin
                pt[k] = a[k];
            end else if (longint'(td) <= tn) begin
                pt[k] = a[k] + d[k];
            end else begin
                mag = (d[k] < 0) ? -d[k] : d[k];
                m = (mag * tq + (64'd1 << 31)) >> 32;
                pt[k] = (d[k] < 0) ? a[k] - longint'(m) : a[k] + longint'(m);
            end
            e = vc[k] - pt[k];
            s += e * e;
        end
        inn = seg_regs[6][RADIUS_W-1:0];
        outr = seg_regs[7][RADIUS_W-1:0];
        if (s <= inn * inn) return FULL_WEIGHT;
        if (outr <= inn) return '0;
        root_d = int_sqrt(s << 8);
        ii = inn << 4;
        span = (outr - inn) << 4;
        if (root_d <= ii) return FULL_WEIGHT;
        nm = root_d - ii;
        if (nm >= span) return '0;
        return t_weight'(65536 - ((nm << 16) / span));
    endfunction

    // Drive vertices: hold until taken, idle in bursts
    always @(negedge i_clk) begin
        logic    next_push;
        t_vertex v;
        next_push = push && !vertex_taken;
        if (i_rst_n && !next_push) begin
            if (push_gap > 0) begin
                push_gap--;
            end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                push_gap = $urandom_range(1, 16);
            end else if (vertex_backlog.size() > 0) begin
                v = vertex_backlog.pop_front();
                i_vertex_x <= v.x;
                i_vertex_y <= v.y;
                i_vertex_z <= v.z;
                next_push = 1'b1;
            end
        end
        push <= next_push;
    end

    // Drive pop with stall bursts
    always @(negedge i_clk) begin
        if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            pop_gap = $urandom_range(1, 16);
            pop <= 1'b0;
        end else begin
            pop <= i_rst_n;
        end
    end

    // Predict on each accepted vertex, check each accepted weight
    always @(posedge i_clk) begin
        t_vertex v;
        t_weight want;
        vertex_taken = push && !full;
        if (vertex_taken) begin
            v.x = i_vertex_x;
            v.y = i_vertex_y;
            v.z = i_vertex_z;
            weight_fifo.push_back(falloff_weight(v));
        end
        if (pop && !empty) begin
            if (weight_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected weight %0d", o_weight);
            end else begin
                want = weight_fifo.pop_front();
                if (o_weight !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("weight mismatch: expected %0d actual %0d", want, o_weight);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [COORD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= CFG_END_Z) seg_regs[idx] = val;
        else if (idx <= CFG_OUTER_RADIUS) seg_regs[idx] = {1'b0, val[RADIUS_W-1:0]};
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (vertex_backlog.size() != 0 || push || weight_fifo.size() != 0);
    endtask

    task automatic load_setup(logic [COORD_W-1:0] s0, s1, s2, e0, e1, e2,
                              logic [COORD_W-1:0] inn, outr);
        write_reg(CFG_START_X, s0);
        write_reg(CFG_START_Y, s1);
        write_reg(CFG_START_Z, s2);
        write_reg(CFG_END_X, e0);
        write_reg(CFG_END_Y, e1);
        write_reg(CFG_END_Z, e2);
        write_reg(CFG_INNER_RADIUS, inn);
        write_reg(CFG_OUTER_RADIUS, outr);
    endtask

    function automatic t_coord sat24(longint x);
        if (x > 8388607) return t_coord'(24'h7FFFFF);
        if (x < -8388608) return t_coord'(24'h800000);
        return t_coord'(x);
    endfunction

    function automatic void queue_vertex(longint x, longint y, longint z);
        t_vertex v;
        v.x = sat24(x);
        v.y = sat24(y);
        v.z = sat24(z);
        vertex_backlog.push_back(v);
    endfunction

    // Mostly vertices around the segment within a few radii, some anywhere
    function automatic void queue_random(int count);
        longint a [3];
        longint d [3];
        longint c [3];
        longint reach;
        int     k;
        reach = longint'(seg_regs[7]) + longint'(seg_regs[6]) + 512;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 3) begin
                queue_vertex($signed(24'($urandom)), $signed(24'($urandom)),
                             $signed(24'($urandom)));
            end else begin
                k = $urandom_range(0, 40);
                for (int j = 0; j < 3; j++) begin
                    a[j] = $signed(seg_regs[j]);
                    d[j] = longint'($signed(seg_regs[3+j])) - a[j];
                    c[j] = a[j] + (d[j] * (k - 4)) / 32
                         + longint'($urandom_range(0, 2 * reach)) - reach;
                end
                queue_vertex(c[0], c[1], c[2]);
            end
        end
    endfunction

    initial begin
        seg_regs = '{default: '0};
        seg_regs[7] = OUTER_RESET;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset setup, field extremes, sphere around origin
        queue_vertex(0, 0, 0);
        queue_vertex(8388607, 8388607, 8388607);
        queue_vertex(-8388608, -8388608, -8388608);
        queue_vertex(8388607, -8388608, 0);
        queue_vertex(25600, 0, 0);
        queue_vertex(0, 12800, 0);
        queue_vertex(0, 0, -25601);
        wait_idle();

        // Segment: vertices at the ends, past the ends, interior, radii edge
        load_setup(24'h000100, 24'hFFFF00, 24'h000000, 24'h002100, 24'h001000,
                   24'h000800, 24'd1280, 24'd3840);
        queue_vertex(256, -256, 0);
        queue_vertex(8448, 4096, 2048);
        queue_vertex(-4000, -3000, -1000);
        queue_vertex(20000, 9000, 5000);
        queue_vertex(4352, 1920, 1024);
        queue_vertex(4352, 1920, 2304);
        queue_vertex(4352, 1920, 4864);
        queue_vertex(4352, 1920, 8000);
        wait_idle();
        // unknown register index must leave the setup alone
        write_reg(t_cfg_idx'(4'd9), 24'hFFFFFF);
        write_reg(t_cfg_idx'(4'd15), 24'h123456);
        queue_random(130);
        wait_idle();

        // Degenerate segment, point selection
        load_setup(24'hFFF000, 24'h000500, 24'h7FF000, 24'hFFF000, 24'h000500,
                   24'h7FF000, 24'd0, 24'd6400);
        queue_vertex(-4096, 1280, 8384512);
        queue_random(130);
        wait_idle();

        // Hard step: outer below inner, then outer equal inner
        load_setup(24'h000000, 24'h000000, 24'h000000, 24'h010000, 24'h000000,
                   24'h000000, 24'd5000, 24'd2000);
        queue_random(120);
        wait_idle();
        write_reg(CFG_OUTER_RADIUS, 24'd5000);
        queue_random(100);
        wait_idle();

        // Extreme segment across the whole space, maximum radii
        load_setup(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                   24'h7FFFFF, 24'h000000, 24'hFFFFFF);
        queue_vertex(8388607, -8388608, 8388607);
        queue_vertex(-8388608, 8388607, 0);
        queue_random(120);
        wait_idle();
        write_reg(CFG_INNER_RADIUS, 24'h7FFFFE);
        queue_random(60);
        wait_idle();

        // Random setups with short segments
        for (int p = 0; p < 3; p++) begin
            load_setup($urandom, $urandom, $urandom, 0, 0, 0,
                       $urandom_range(0, 3000), $urandom_range(0, 20000));
            for (int j = 0; j < 3; j++)
                write_reg(t_cfg_idx'(3 + j), 24'($signed(seg_regs[j])
                          + $signed(24'($urandom_range(0, 16000))) - 8000));
            queue_random(100);
            wait_idle();
        end

        // Last stretch runs without idling on either side
        quiet_mode = 1;
        load_setup(24'h001000, 24'h002000, 24'h003000, 24'h00F000, 24'hFF8000,
                   24'h004000, 24'd256, 24'd51200);
        queue_random(110);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && weight_fifo.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
